### src/npsrch_pkg.sv
// Package for the nearest point search block: types, codes and defaults.
package npsrch_pkg;

    localparam int FIELD_W         = 24;
    localparam int INDEX_OUT_W     = 8;
    localparam int MAX_POINTS_DEF  = 256;
    localparam int COORD_BITS_DEF  = 24;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_NEAR   = 2'd2;
    localparam logic [1:0] MODE_MATCH  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
    } npsrch_in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [INDEX_OUT_W-1:0] point_index;
    } npsrch_out_t;

endpackage

### src/npsrch_cell.sv
// One axis cell of the scan chain: difference, square and accumulate.
module npsrch_cell #(
    parameter int CB    = 24,
    parameter int IDX_W = 8,
    parameter int ACC_W = 2 * CB + 2,
    parameter int AXIS  = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_load,
    input  logic [CB-1:0]          q_coord,
    input  logic                   in_valid,
    input  logic                   in_last,
    input  logic [IDX_W-1:0]       in_idx,
    input  logic                   in_match,
    input  logic [ACC_W-1:0]       in_acc,
    input  logic [2:0][CB-1:0]     in_pt,
    output logic                   out_valid,
    output logic                   out_last,
    output logic [IDX_W-1:0]       out_idx,
    output logic                   out_match,
    output logic [ACC_W-1:0]       out_acc,
    output logic [2:0][CB-1:0]     out_pt
);
    logic [CB-1:0]      q_reg;
    logic signed [CB:0] diff;
    logic [CB-1:0]      mag;
    logic [2*CB-1:0]    sq;

    // stage a: abs difference
    logic               va_reg, lasta_reg, matcha_reg;
    logic [IDX_W-1:0]   idxa_reg;
    logic [ACC_W-1:0]   acca_reg;
    logic [2:0][CB-1:0] pta_reg;
    logic [CB-1:0]      maga_reg;
    // stage b: square and accumulate
    logic               vb_reg, lastb_reg, matchb_reg;
    logic [IDX_W-1:0]   idxb_reg;
    logic [ACC_W-1:0]   accb_reg, accb_next;
    logic [2:0][CB-1:0] ptb_reg;

    assign diff = {in_pt[AXIS][CB-1], in_pt[AXIS]} - {q_reg[CB-1], q_reg};
    assign mag  = diff[CB] ? CB'(-diff) : diff[CB-1:0];
    assign sq   = maga_reg * maga_reg;
    assign accb_next = acca_reg + ACC_W'(sq);

    always_ff @(posedge aclk) begin
        if (q_load) begin
            q_reg <= q_coord;
        end
        lasta_reg  <= in_last;
        idxa_reg   <= in_idx;
        matcha_reg <= in_match && (diff == '0);
        acca_reg   <= in_acc;
        pta_reg    <= in_pt;
        maga_reg   <= mag;
        lastb_reg  <= lasta_reg;
        idxb_reg   <= idxa_reg;
        matchb_reg <= matcha_reg;
        accb_reg   <= accb_next;
        ptb_reg    <= pta_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_last  = lastb_reg;
    assign out_idx   = idxb_reg;
    assign out_match = matchb_reg;
    assign out_acc   = accb_reg;
    assign out_pt    = ptb_reg;
endmodule

### src/nearest_point_search.sv
// Nearest point search: point table plus a three-cell distance chain.
// Clear and append: the item moves the state to DONE on accept, and the result is registered out from there.
// Queries: one point read per cycle into three axis cells of two stages each;
// the result is registered out after the last point leaves the chain. No new item
// of any mode is accepted until the result has been loaded into the output.
// Reset (aresetn, synchronous, active low) empties the table; points are not cleared.
module nearest_point_search #(
    parameter int MAX_POINTS = npsrch_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = npsrch_pkg::COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  npsrch_pkg::npsrch_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output npsrch_pkg::npsrch_out_t m_data
);
    import npsrch_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ACC_W = 2 * CB + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    // sign-extended item coordinates, taken in their low CB bits
    logic [31:0]   ext_x, ext_y, ext_z;
    logic [CB-1:0] in_x, in_y, in_z;
    assign ext_x = {{(32 - FIELD_W){s_data.coord_x[FIELD_W-1]}}, s_data.coord_x};
    assign ext_y = {{(32 - FIELD_W){s_data.coord_y[FIELD_W-1]}}, s_data.coord_y};
    assign ext_z = {{(32 - FIELD_W){s_data.coord_z[FIELD_W-1]}}, s_data.coord_z};
    assign in_x  = ext_x[CB-1:0];
    assign in_y  = ext_y[CB-1:0];
    assign in_z  = ext_z[CB-1:0];

    logic accept;
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [1:0]       mode_reg;
    logic [1:0]       res_status_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             table_full;
    assign table_full = (count_reg == CNT_W'(MAX_POINTS));

    // point table, one array per axis
    logic [CB-1:0] mem_x [MAX_POINTS];
    logic [CB-1:0] mem_y [MAX_POINTS];
    logic [CB-1:0] mem_z [MAX_POINTS];
    logic          wr_en, issue;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [2:0][CB-1:0] rd_pt_reg;
    logic             rd_valid_reg, rd_last_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    assign wr_en   = accept && (s_data.mode == MODE_APPEND) && !table_full;
    assign wr_addr = count_reg[IDX_W-1:0];
    assign issue   = (state_reg == S_SCAN) && (scan_cnt_reg < count_reg);
    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= in_x;
            mem_y[wr_addr] <= in_y;
            mem_z[wr_addr] <= in_z;
        end
        rd_pt_reg[0] <= mem_x[rd_addr];
        rd_pt_reg[1] <= mem_y[rd_addr];
        rd_pt_reg[2] <= mem_z[rd_addr];
        rd_idx_reg   <= rd_addr;
        rd_last_reg  <= (scan_cnt_reg == count_reg - CNT_W'(1));
    end

    // chain of axis cells: x, then y, then z
    logic [3:0]               c_valid, c_last, c_match;
    logic [3:0][IDX_W-1:0]    c_idx;
    logic [3:0][ACC_W-1:0]    c_acc;
    logic [3:0][2:0][CB-1:0]  c_pt;
    logic [2:0][CB-1:0]       q_in;

    assign c_valid[0] = rd_valid_reg;
    assign c_last[0]  = rd_last_reg;
    assign c_idx[0]   = rd_idx_reg;
    assign c_match[0] = 1'b1;
    assign c_acc[0]   = '0;
    assign c_pt[0]    = rd_pt_reg;
    assign q_in[0]    = in_x;
    assign q_in[1]    = in_y;
    assign q_in[2]    = in_z;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        npsrch_cell #(
            .CB    (CB),
            .IDX_W (IDX_W),
            .ACC_W (ACC_W),
            .AXIS  (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .q_load    (accept),
            .q_coord   (q_in[k]),
            .in_valid  (c_valid[k]),
            .in_last   (c_last[k]),
            .in_idx    (c_idx[k]),
            .in_match  (c_match[k]),
            .in_acc    (c_acc[k]),
            .in_pt     (c_pt[k]),
            .out_valid (c_valid[k+1]),
            .out_last  (c_last[k+1]),
            .out_idx   (c_idx[k+1]),
            .out_match (c_match[k+1]),
            .out_acc   (c_acc[k+1]),
            .out_pt    (c_pt[k+1])
        );
    end

    // best-so-far tracker at the tail of the chain
    logic             found_reg;
    logic [ACC_W-1:0] best_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             take;

    always_comb begin
        take = 1'b0;
        if (c_valid[3]) begin
            if (mode_reg == MODE_NEAR) begin
                take = !found_reg || (c_acc[3] < best_reg);
            end else begin
                take = !found_reg && c_match[3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_reg     <= c_acc[3];
            best_idx_reg <= c_idx[3];
        end
    end

    // result to present
    logic [1:0]       fin_status;
    logic [IDX_W-1:0] fin_idx;
    logic [IDX_W+INDEX_OUT_W-1:0] fin_idx_ext;
    logic             m_load;

    always_comb begin
        if (mode_reg == MODE_NEAR || mode_reg == MODE_MATCH) begin
            fin_status = found_reg ? ST_OK : ST_NONE;
            fin_idx    = found_reg ? best_idx_reg : '0;
        end else begin
            fin_status = res_status_reg;
            fin_idx    = res_idx_reg;
        end
    end
    assign fin_idx_ext = {{INDEX_OUT_W{1'b0}}, fin_idx};
    assign m_load = (state_reg == S_DONE) && (!m_valid || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if ((s_data.mode == MODE_NEAR || s_data.mode == MODE_MATCH)
                        && (count_reg != '0)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (c_valid[3] && c_last[3]) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (m_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= s_data.mode;
            case (s_data.mode)
                MODE_APPEND: begin
                    res_status_reg <= table_full ? ST_FULL : ST_OK;
                    res_idx_reg    <= table_full ? '0 : wr_addr;
                end
                default: begin
                    res_status_reg <= ST_OK;
                    res_idx_reg    <= '0;
                end
            endcase
        end
        if (m_load) begin
            m_data.status      <= fin_status;
            m_data.point_index <= fin_idx_ext[INDEX_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (accept) begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
                if (s_data.mode == MODE_CLEAR) begin
                    count_reg <= '0;
                end else if (wr_en) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end else begin
                if (issue) begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
            if (m_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end
endmodule
